// ===== src/emgrms_pkg.sv =====
//------------------------------------------------------------------------------
// emgrms_pkg
// Shared types and constants of the EMG RMS onset detector.
//------------------------------------------------------------------------------
package emgrms_pkg;

	localparam int SAMPLE_W = 12;
	localparam int RMS_W    = 13;
	localparam int PCT_W    = 16;
	localparam int TICK_W   = 16;
	localparam int CAP_W    = 29;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int DEFAULT_WINDOW = 64;

	localparam logic [11:0] RST_OFFSET = 12'd1330;
	localparam logic [15:0] RST_THRESH = 16'd5120;
	localparam logic [15:0] RST_OPEN   = 16'd50;
	localparam logic [15:0] RST_CLOSE  = 16'd300;
	localparam logic [15:0] RST_CAPLEN = 16'd1000;
	localparam logic [15:0] PCT_SCALE  = 16'd25600;
	localparam logic [12:0] RMS_MAX    = 13'd4095;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET = 3'd0,
		CFG_THRESH = 3'd1,
		CFG_OPEN   = 3'd2,
		CFG_CLOSE  = 3'd3,
		CFG_CAPLEN = 3'd4
	} cfg_idx_t;

	// item commands
	localparam logic [1:0] FUNC_SAMPLE = 2'd0;
	localparam logic [1:0] FUNC_START  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	typedef struct packed {
		logic [SAMPLE_W-1:0] emg_sample;
		logic [1:0]          func;
	} in_item_t;

	typedef struct packed {
		logic [RMS_W-1:0] rms_level;
		logic [PCT_W-1:0] normalized_pct;
		logic             arm_open;
		logic             capture_busy;
		logic             level_valid;
		logic [RMS_W-1:0] captured_level;
	} out_item_t;

	// queued work from front to back
	typedef struct packed {
		logic signed [RMS_W-1:0] d;
		logic [1:0]              func;
	} job_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_offset;
		logic [PCT_W-1:0]    open_threshold_pct;
		logic [TICK_W-1:0]   open_ticks;
		logic [TICK_W-1:0]   close_ticks;
		logic [TICK_W-1:0]   capture_length;
	} cfg_t;

endpackage

// ===== src/emgrms_if.sv =====
//------------------------------------------------------------------------------
// emgrms channel interfaces
// Valid/ready channels for items, results and configuration writes.
//------------------------------------------------------------------------------
interface emgrms_in_if;
	import emgrms_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface emgrms_out_if;
	import emgrms_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface emgrms_cfg_if;
	import emgrms_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== src/emgrms_front.sv =====
//------------------------------------------------------------------------------
// emgrms_front
// Accepts items, removes the offset and queues them in a two-entry FIFO.
//------------------------------------------------------------------------------
module emgrms_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  emgrms_pkg::in_item_t              in_data,
	input  logic [emgrms_pkg::SAMPLE_W-1:0]   sample_offset,
	output logic                              job_valid,
	input  logic                              job_ready,
	output emgrms_pkg::job_t                  job
);
	import emgrms_pkg::*;

	job_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	job_t       new_job;

	assign in_ready  = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job       = fifo_q[rd_ptr_q];
	assign push      = in_valid & in_ready;
	assign pop       = job_valid & job_ready;

	// offset removal
	always_comb begin
		new_job.d    = $signed({1'b0, in_data.emg_sample}) - $signed({1'b0, sample_offset});
		new_job.func = in_data.func;
	end

	// payload store
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= new_job;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== src/emgrms_back.sv =====
//------------------------------------------------------------------------------
// emgrms_back
// Ring, square sum, bit-serial root and divides, capture and debounce.
//------------------------------------------------------------------------------
module emgrms_back #(
	parameter int WINDOW = emgrms_pkg::DEFAULT_WINDOW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	output logic                  job_ready,
	input  emgrms_pkg::job_t      job,
	input  emgrms_pkg::cfg_t      cfg,
	output logic                  out_valid,
	input  logic                  out_ready,
	output emgrms_pkg::out_item_t out_data
);
	import emgrms_pkg::*;

	localparam int PW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SQW  = 24 + $clog2(WINDOW + 1);
	localparam int MW   = 24;
	localparam int QW   = 29;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_READ  = 8'b00000010,
		ST_UPD   = 8'b00000100,
		ST_SQRT  = 8'b00001000,
		ST_CAP   = 8'b00010000,
		ST_DIV   = 8'b00100000,
		ST_PCT   = 8'b01000000,
		ST_OUT   = 8'b10000000
	} state_t;

	state_t state_q;

	// ring memory, reset-cleared by valid bits
	logic signed [RMS_W-1:0] ring_mem [WINDOW];
	logic [WINDOW-1:0]       ring_vld_q;
	logic signed [RMS_W-1:0] old_q;
	logic [PW-1:0]           ptr_q;

	logic [SQW-1:0]          sq_sum_q;
	logic signed [RMS_W-1:0] d_q;
	logic [1:0]              func_q;

	// square root state
	logic [MW-1:0]   rem_q;
	logic [RMS_W-1:0] root_q;
	logic [3:0]      step_q;
	logic [RMS_W-1:0] rms_q;

	// capture state
	logic [CAP_W-1:0] cap_sum_q;
	logic [TICK_W-1:0] cap_cnt_q;
	logic             capturing_q;
	logic [RMS_W-1:0] ref_q;
	logic             ref_vld_q;

	// shared restoring divider
	logic [QW-1:0]    dnum_q;
	logic [QW-1:0]    dquo_q;
	logic [TICK_W:0]  drem_q;
	logic [TICK_W-1:0] dden_q;
	logic [4:0]       dcnt_q;
	logic             div_pct_q;

	logic [PCT_W-1:0] pct_q;
	logic             was_above_q;
	logic [TICK_W-1:0] persist_q;
	logic             arm_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [MW-1:0]    mag_new, mag_old;
	logic [11:0]      abs_new, abs_old;
	logic [MW-1:0]    trial;
	logic [TICK_W:0]  drem_sh;
	logic             dbit;
	logic [QW-1:0]    quo_full;
	logic             above;
	logic [TICK_W-1:0] persist_inc;
	logic             arm_set, arm_clr;
	logic             publish;

	assign job_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign publish   = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		abs_new = d_q[RMS_W-1] ? 12'(-d_q) : d_q[11:0];
		abs_old = old_q[RMS_W-1] ? 12'(-old_q) : old_q[11:0];
		mag_new = MW'(abs_new) * MW'(abs_new);
		mag_old = MW'(abs_old) * MW'(abs_old);
		trial   = rem_q - MW'({root_q, 2'b01} << (2 * step_q));
		drem_sh = {drem_q[TICK_W-1:0], dnum_q[QW-1]};
		dbit    = (drem_sh >= {1'b0, dden_q});
		quo_full = {dquo_q[QW-2:0], dbit};
		above   = pct_q > cfg.open_threshold_pct;
		persist_inc = persist_q + 1'b1;
		arm_set = (above == was_above_q) && above && (persist_inc >= cfg.open_ticks);
		arm_clr = (above == was_above_q) && !above && (persist_inc >= cfg.close_ticks);
	end

	// ring write and read; unwritten entries read as zero
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid && job_ready) begin
			old_q <= ring_vld_q[ptr_q] ? ring_mem[ptr_q] : '0;
		end
		if (state_q == ST_READ) ring_mem[ptr_q] <= d_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ring_vld_q  <= '0;
			ptr_q       <= '0;
			sq_sum_q    <= '0;
			d_q         <= '0;
			func_q      <= '0;
			rem_q       <= '0;
			root_q      <= '0;
			step_q      <= '0;
			rms_q       <= '0;
			cap_sum_q   <= '0;
			cap_cnt_q   <= '0;
			capturing_q <= 1'b0;
			ref_q       <= '0;
			ref_vld_q   <= 1'b0;
			dnum_q      <= '0;
			dquo_q      <= '0;
			drem_q      <= '0;
			dden_q      <= '0;
			dcnt_q      <= '0;
			div_pct_q   <= 1'b0;
			pct_q       <= '0;
			was_above_q <= 1'b0;
			persist_q   <= '0;
			arm_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (publish) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_valid && job_ready) begin
						d_q     <= job.d;
						func_q  <= job.func;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					ring_vld_q[ptr_q] <= 1'b1;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					sq_sum_q <= sq_sum_q - SQW'(mag_old) + SQW'(mag_new);
					ptr_q    <= (ptr_q == PW'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
					state_q  <= ST_SQRT;
					step_q   <= 4'd12;
					root_q   <= '0;
				end
				ST_SQRT: begin
					// one result bit per cycle, MSB first
					if (step_q == 4'd12) begin
						rem_q  <= MW'((sq_sum_q / WINDOW) > SQW'({MW{1'b1}}) ?
							{MW{1'b1}} : MW'(sq_sum_q / WINDOW));
						step_q <= 4'd11;
					end else begin
						if (rem_q >= MW'({root_q, 2'b01} << (2 * step_q))) begin
							rem_q  <= trial;
							root_q <= {root_q[RMS_W-2:0], 1'b1};
						end else begin
							root_q <= {root_q[RMS_W-2:0], 1'b0};
						end
						if (step_q == 4'd0) state_q <= ST_CAP;
						else step_q <= step_q - 1'b1;
					end
				end
				ST_CAP: begin
					rms_q   <= (root_q > RMS_MAX) ? RMS_MAX : root_q;
					begin : cap_blk
						logic cap_n;
						logic fin_n;
						logic [TICK_W-1:0] cnt_n;
						logic [CAP_W-1:0]  sum_n;
						cap_n = capturing_q;
						fin_n = 1'b0;
						cnt_n = cap_cnt_q;
						sum_n = cap_sum_q;
						if (func_q == FUNC_START && !capturing_q) begin
							cap_n = 1'b1; cnt_n = '0; sum_n = '0;
						end else if (func_q == FUNC_CLEAR) begin
							ref_q <= '0; cap_n = 1'b0; cnt_n = '0;
						end
						if (cap_n) begin
							if (cnt_n < cfg.capture_length) begin
								sum_n = sum_n + CAP_W'(root_q);
								cnt_n = cnt_n + 1'b1;
							end else begin
								cap_n = 1'b0; cnt_n = '0; fin_n = 1'b1;
								ref_vld_q <= 1'b1;
								dnum_q <= sum_n; dden_q <= cfg.capture_length;
								drem_q <= '0; dcnt_q <= 5'd0; div_pct_q <= 1'b0;
							end
						end
						capturing_q <= cap_n;
						cap_cnt_q   <= cnt_n;
						cap_sum_q   <= sum_n;
						state_q     <= fin_n ? ST_DIV : ST_PCT;
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit per cycle
					drem_q <= dbit ? drem_sh - {1'b0, dden_q} : drem_sh;
					dquo_q <= quo_full;
					dnum_q <= dnum_q << 1;
					if (dcnt_q == 5'd28) begin
						if (div_pct_q) begin
							pct_q <= (quo_full > QW'(16'hFFFF)) ? 16'hFFFF :
								quo_full[PCT_W-1:0];
							state_q <= ST_OUT;
						end else begin
							// zero capture length gives a zero level
							ref_q <= (dden_q == '0) ? '0 :
								(quo_full > QW'(RMS_MAX)) ? RMS_MAX : quo_full[RMS_W-1:0];
							state_q <= ST_PCT;
						end
					end else begin
						dcnt_q <= dcnt_q + 1'b1;
					end
				end
				ST_PCT: begin
					if (!ref_vld_q) begin
						pct_q <= '0; state_q <= ST_OUT;
					end else if (ref_q == '0) begin
						pct_q <= (rms_q != '0) ? 16'hFFFF : 16'h0; state_q <= ST_OUT;
					end else begin
						dnum_q <= QW'(rms_q * PCT_SCALE);
						dden_q <= TICK_W'(ref_q);
						drem_q <= '0; dcnt_q <= 5'd0; div_pct_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_OUT: begin
					// debounce then publish once the result register is free
					if (publish) begin
						if (above != was_above_q || arm_set || arm_clr) persist_q <= '0;
						else persist_q <= persist_inc;
						if (arm_set) arm_q <= 1'b1;
						else if (arm_clr) arm_q <= 1'b0;
						was_above_q <= above;
						out_q.rms_level      <= rms_q;
						out_q.normalized_pct <= pct_q;
						out_q.arm_open       <= arm_set ? 1'b1 : arm_clr ? 1'b0 : arm_q;
						out_q.capture_busy   <= capturing_q;
						out_q.level_valid    <= ref_vld_q;
						out_q.captured_level <= ref_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/emg_rms_onset_detector.sv =====
//------------------------------------------------------------------------------
// emg_rms_onset_detector
// Moving-window RMS of an EMG channel with capture-normalised onset detection.
//------------------------------------------------------------------------------
// channel | dir | transfer
// in_ch   | in  | emg_sample, func
// out_ch  | out | rms_level .. captured_level
// cfg_ch  | in  | index, wdata register write
//
// An item passes the ring read and update, the bit-serial root, the capture step,
// a restoring divide of the capture sum when a capture ends, a percent divide
// once a nonzero level is held, and the publish step.
// The input queue holds two items while the back end works; a stalled result
// register holds the back end at its publish step only. Reset clears all
// state; the ring is cleared by per-entry valid bits, no clearing pass.
//------------------------------------------------------------------------------
module emg_rms_onset_detector #(
	parameter int WINDOW = emgrms_pkg::DEFAULT_WINDOW
) (
	input  logic           clk,
	input  logic           arst_n,
	emgrms_in_if.sink      in_ch,
	emgrms_out_if.source   out_ch,
	emgrms_cfg_if.sink     cfg_ch
);
	import emgrms_pkg::*;

	cfg_t cfg_q;
	logic job_valid, job_ready;
	job_t job;

	assign cfg_ch.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_offset      <= RST_OFFSET;
			cfg_q.open_threshold_pct <= RST_THRESH;
			cfg_q.open_ticks         <= RST_OPEN;
			cfg_q.close_ticks        <= RST_CLOSE;
			cfg_q.capture_length     <= RST_CAPLEN;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				CFG_OFFSET: cfg_q.sample_offset      <= cfg_ch.wdata[SAMPLE_W-1:0];
				CFG_THRESH: cfg_q.open_threshold_pct <= cfg_ch.wdata;
				CFG_OPEN:   cfg_q.open_ticks         <= cfg_ch.wdata;
				CFG_CLOSE:  cfg_q.close_ticks        <= cfg_ch.wdata;
				CFG_CAPLEN: cfg_q.capture_length     <= cfg_ch.wdata;
				default: ;
			endcase
		end
	end

	emgrms_front u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.sample_offset(cfg_q.sample_offset),
		.job_valid, .job_ready, .job
	);

	emgrms_back #(.WINDOW(WINDOW)) u_back (
		.clk, .arst_n,
		.job_valid, .job_ready, .job, .cfg(cfg_q),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);

	// result holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed under stall");
	// level valid never falls
	a_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_ch.valid) && out_ch.valid && $past(out_ch.data.level_valid)
		|-> out_ch.data.level_valid)
		else $error("level_valid fell");
	// rms saturates
	a_rms: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.data.rms_level <= RMS_MAX)
		else $error("rms out of range");

endmodule
